FILE: hdl/four_neighbour_peak_clip_top_assert.svh
// Assertion macros shared by the four-neighbour peak clip RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef FOUR_NEIGHBOUR_PEAK_CLIP_TOP_ASSERT_SVH
`define FOUR_NEIGHBOUR_PEAK_CLIP_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define FNPC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("fnpc: assertion failed");

// Next-cycle implication, disabled while in reset
`define FNPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("fnpc: assertion failed");

`endif

FILE: hdl/fnpc_pkg.sv
// Package for the four-neighbour peak clip: sizes, types, register codes
// and slot helpers. No dependencies.
package fnpc_pkg;

  localparam int MAX_WIDTH  = 32;
  localparam int PIXEL_BITS = 32;
  localparam int ROWS       = 3;
  localparam int DEPTH      = ROWS * MAX_WIDTH;
  localparam int COL_BITS   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ADDR_BITS  = $clog2(DEPTH);
  localparam int SLOT_BITS  = 2;
  localparam int WREG_BITS  = 6;
  localparam int ROW_BITS   = 16;

  typedef logic [PIXEL_BITS-1:0] pixel_t;
  typedef logic [COL_BITS-1:0]   col_t;
  typedef logic [ADDR_BITS-1:0]  addr_t;
  typedef logic [SLOT_BITS-1:0]  slot_t;

  // register word index (paddr[2])
  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic take;       // pixel leaves the input register, store write
    logic step;       // window shift / column advance
    logic emit;       // load the result register
    logic load_pix;   // one-pixel rows: next center is the incoming pixel
    logic left_ok;
    logic right_ok;
    logic up_ok;
    logic down_ok;
    logic last_run;
    logic frame_done;
  } ctl_t;

  function automatic slot_t slot_inc(slot_t s);
    slot_inc = (s == 2'd2) ? 2'd0 : s + 2'd1;
  endfunction

  function automatic slot_t slot_dec(slot_t s);
    slot_dec = (s == 2'd0) ? 2'd2 : s - 2'd1;
  endfunction

  function automatic addr_t row_addr(slot_t s, col_t c);
    row_addr = ADDR_BITS'(s) * ADDR_BITS'(MAX_WIDTH) + ADDR_BITS'(c);
  endfunction

endpackage

FILE: hdl/fnpc_line_store.sv
// Three-row line store: one write port, two registered read ports with
// write-to-read bypass. Depends on fnpc_pkg.
module fnpc_line_store (
  input  logic            clk_i,
  input  logic            we_i,
  input  fnpc_pkg::addr_t waddr_i,
  input  fnpc_pkg::pixel_t wdata_i,
  input  fnpc_pkg::addr_t raddr_a_i,
  input  fnpc_pkg::addr_t raddr_b_i,
  output fnpc_pkg::pixel_t rdata_a_o,
  output fnpc_pkg::pixel_t rdata_b_o
);
  import fnpc_pkg::*;

  pixel_t mem_q [DEPTH];
  pixel_t rd_a_q, rd_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_a_i)) begin
      rd_a_q <= wdata_i;
    end else begin
      rd_a_q <= mem_q[raddr_a_i];
    end
    if (we_i && (waddr_i == raddr_b_i)) begin
      rd_b_q <= wdata_i;
    end else begin
      rd_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rd_a_q;
  assign rdata_b_o = rd_b_q;

endmodule

FILE: hdl/fnpc_seq.sv
// Position sequencer: column/row/slot counters, end-of-frame row flush,
// store addresses and per-transfer control. Depends on fnpc_pkg and the
// assertion macro header.
`include "four_neighbour_peak_clip_top_assert.svh"

module fnpc_seq (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_wr_i,
  input  logic [fnpc_pkg::WREG_BITS-1:0]   frame_width_i,
  input  logic [fnpc_pkg::ROW_BITS-1:0]    frame_height_i,
  input  logic                             in_valid_i,
  input  logic                             out_free_i,
  output fnpc_pkg::ctl_t                   ctl_o,
  output fnpc_pkg::addr_t                  waddr_o,
  output fnpc_pkg::addr_t                  raddr_a_o,
  output fnpc_pkg::addr_t                  raddr_b_o
);
  import fnpc_pkg::*;

  col_t                col_q, col_d;
  logic [ROW_BITS-1:0] row_q, row_d;
  slot_t               slot_q, slot_d;
  logic                flush_q, flush_d;

  logic [WREG_BITS-1:0] w_eff;
  col_t                 last_col;
  logic [ROW_BITS-1:0]  last_row;
  logic                 at_row_end, final_pix, advance, flush_emit;

  always_comb begin
    if (frame_width_i == '0) begin
      w_eff = WREG_BITS'(1);
    end else if (frame_width_i > WREG_BITS'(MAX_WIDTH)) begin
      w_eff = WREG_BITS'(MAX_WIDTH);
    end else begin
      w_eff = frame_width_i;
    end
  end

  assign last_col   = COL_BITS'(w_eff - WREG_BITS'(1));
  assign last_row   = (frame_height_i == '0) ? '0 : frame_height_i - ROW_BITS'(1);
  assign at_row_end = (col_q == last_col);
  assign final_pix  = at_row_end && (row_q == last_row);
  assign advance    = !flush_q && in_valid_i && ((row_q == '0) || out_free_i);
  assign flush_emit = flush_q && out_free_i;

  always_comb begin
    ctl_o.take       = advance;
    ctl_o.step       = advance || flush_emit;
    ctl_o.emit       = (advance && (row_q != '0)) || flush_emit;
    ctl_o.load_pix   = !flush_q && at_row_end && (last_col == '0);
    ctl_o.left_ok    = (col_q != '0);
    ctl_o.right_ok   = !at_row_end;
    ctl_o.up_ok      = flush_q ? (last_row != '0) : (row_q > ROW_BITS'(1));
    ctl_o.down_ok    = !flush_q;
    ctl_o.last_run   = flush_q ? at_row_end : !final_pix;
    ctl_o.frame_done = flush_q && at_row_end;
  end

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    slot_d  = slot_q;
    flush_d = flush_q;
    if (cfg_wr_i) begin
      col_d   = '0;
      row_d   = '0;
      slot_d  = '0;
      flush_d = 1'b0;
    end else if (advance) begin
      if (final_pix) begin
        // last row is flushed as a virtual row below the frame
        col_d   = '0;
        row_d   = '0;
        slot_d  = slot_inc(slot_q);
        flush_d = 1'b1;
      end else if (at_row_end) begin
        col_d  = '0;
        row_d  = row_q + ROW_BITS'(1);
        slot_d = slot_inc(slot_q);
      end else begin
        col_d = col_q + COL_BITS'(1);
      end
    end else if (flush_emit) begin
      if (at_row_end) begin
        col_d   = '0;
        slot_d  = '0;
        flush_d = 1'b0;
      end else begin
        col_d = col_q + COL_BITS'(1);
      end
    end
  end

  // reads prefetch for the next position; at row end port A fetches the
  // next row's first pixel as the upcoming center
  always_comb begin
    if ((col_d == last_col) && !flush_d) begin
      raddr_a_o = row_addr(slot_d, '0);
    end else begin
      raddr_a_o = row_addr(slot_dec(slot_d), col_d + COL_BITS'(1));
    end
    raddr_b_o = row_addr(slot_dec(slot_dec(slot_d)), col_d);
    waddr_o   = row_addr(slot_q, col_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      slot_q  <= '0;
      flush_q <= 1'b0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      slot_q  <= slot_d;
      flush_q <= flush_d;
    end
  end

  `FNPC_ASSERT_NEXT(a_final_starts_flush, clk_i, rst_ni, advance && final_pix && !cfg_wr_i, flush_q && (col_q == '0))
  `FNPC_ASSERT_NEXT(a_flush_ends, clk_i, rst_ni, flush_emit && at_row_end && !cfg_wr_i, !flush_q && (col_q == '0) && (row_q == '0) && (slot_q == '0))
  `FNPC_ASSERT_IMPL(a_col_in_row, clk_i, rst_ni, 1'b1, col_q <= last_col)
  `FNPC_ASSERT_IMPL(a_flush_row_zero, clk_i, rst_ni, flush_q, row_q == '0)

endmodule

FILE: hdl/fnpc_clip.sv
// Neighbour window (left and center registers) and the peak clip datapath.
// Depends on fnpc_pkg.
module fnpc_clip (
  input  logic             clk_i,
  input  fnpc_pkg::ctl_t   ctl_i,
  input  fnpc_pkg::pixel_t pixel_i,
  input  fnpc_pkg::pixel_t right_i,
  input  fnpc_pkg::pixel_t up_i,
  output fnpc_pkg::pixel_t result_o
);
  import fnpc_pkg::*;

  pixel_t lft_q, ctr_q;
  pixel_t up_v, down_v, left_v, right_v, max_ud, max_lr, max_all;

  always_ff @(posedge clk_i) begin
    if (ctl_i.step) begin
      lft_q <= ctr_q;
      ctr_q <= ctl_i.load_pix ? pixel_i : right_i;
    end
  end

  always_comb begin
    up_v    = ctl_i.up_ok    ? up_i    : '0;
    down_v  = ctl_i.down_ok  ? pixel_i : '0;
    left_v  = ctl_i.left_ok  ? lft_q   : '0;
    right_v = ctl_i.right_ok ? right_i : '0;
    max_ud  = (up_v > down_v) ? up_v : down_v;
    max_lr  = (left_v > right_v) ? left_v : right_v;
    max_all = (max_ud > max_lr) ? max_ud : max_lr;
    result_o = (ctr_q > max_all) ? max_all : ctr_q;
  end

endmodule

FILE: hdl/four_neighbour_peak_clip_top.sv
// Top level of the four-neighbour peak clip: APB registers, input and
// result registers. Depends on fnpc_pkg, fnpc_seq, fnpc_line_store, fnpc_clip.
//
// channel   | direction | transfer on             | payload
// s_axis    | in        | tvalid & tready         | tdata: pixel_in
// m_axis    | out       | tvalid & tready         | tdata: pixel_out, tlast, tuser
// apb       | in        | psel&penable&pwrite     | frame_width @0, frame_height @4
//
// One pixel per cycle sustained while results are accepted and no flush runs; the
// pixel store allows one write and two prefetched reads per cycle. The result
// caused by an input transfer is loaded into the result register when that pixel
// leaves the input register. A frame's last pixel starts a flush of the last row,
// one result per column; meanwhile at most one more pixel enters the input register.
// Reset clears control only; the row store needs no clearing pass.
// Either side may stall; the input register takes a pixel while a result waits.
module four_neighbour_peak_clip_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] pixel_in
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] pixel_out
  output logic        m_axis_tlast_o,   // last_of_run
  output logic [0:0]  m_axis_tuser_o,   // [0] frame_done
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fnpc_pkg::*;

  logic [WREG_BITS-1:0] width_q;
  logic [ROW_BITS-1:0]  height_q;
  logic                 cfg_wr;

  logic   in_valid_q;
  pixel_t in_data_q;
  logic   out_valid_q, out_last_q, out_done_q, out_free;
  pixel_t out_data_q;

  ctl_t   ctl;
  addr_t  waddr, raddr_a, raddr_b;
  pixel_t rd_a, rd_b, result;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WREG_BITS'(MAX_WIDTH);
      height_q <= ROW_BITS'(1);
    end else if (cfg_wr) begin
      case (reg_idx_e'(paddr[2]))
        REG_FRAME_WIDTH:  width_q  <= pwdata[WREG_BITS-1:0];
        REG_FRAME_HEIGHT: height_q <= pwdata[ROW_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[2]))
      REG_FRAME_WIDTH:  prdata = 32'(width_q);
      REG_FRAME_HEIGHT: prdata = 32'(height_q);
      default:          prdata = '0;
    endcase
  end

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || ctl.take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_valid_q <= 1'b1;
    end else if (ctl.take) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_data_q <= s_axis_tdata_i;
    end
  end

  fnpc_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_wr_i       (cfg_wr),
    .frame_width_i  (width_q),
    .frame_height_i (height_q),
    .in_valid_i     (in_valid_q),
    .out_free_i     (out_free),
    .ctl_o          (ctl),
    .waddr_o        (waddr),
    .raddr_a_o      (raddr_a),
    .raddr_b_o      (raddr_b)
  );

  fnpc_line_store u_store (
    .clk_i     (clk_i),
    .we_i      (ctl.take),
    .waddr_i   (waddr),
    .wdata_i   (in_data_q),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  fnpc_clip u_clip (
    .clk_i    (clk_i),
    .ctl_i    (ctl),
    .pixel_i  (in_data_q),
    .right_i  (rd_a),
    .up_i     (rd_b),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.emit) begin
      out_data_q <= result;
      out_last_q <= ctl.last_run;
      out_done_q <= ctl.frame_done;
    end
  end

  assign m_axis_tvalid_o   = out_valid_q;
  assign m_axis_tdata_o    = out_data_q;
  assign m_axis_tlast_o    = out_last_q;
  assign m_axis_tuser_o[0] = out_done_q;

endmodule

FILE: verif/four_neighbour_peak_clip_top_test.sv
// Self-checking test of four_neighbour_peak_clip_top: random-gap stream driver,
// output checker against a behavioral clip predictor, APB frame-size setup.
// Depends on fnpc_pkg and the four_neighbour_peak_clip_top RTL.
module four_neighbour_peak_clip_top_test;
  import fnpc_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE     = 40;

  typedef struct packed {
    pixel_t pix;
    logic   last;
    logic   done;
  } clip_result_t;

  logic        clk    = 1'b0;
  logic        rst_n  = 1'b0;
  logic        s_valid = 1'b0;
  logic [31:0] s_data  = '0;
  logic        m_ready = 1'b0;
  logic        psel_r    = 1'b0;
  logic        penable_r = 1'b0;
  logic        pwrite_r  = 1'b0;
  logic [2:0]  paddr_r   = '0;
  logic [31:0] pwdata_r  = '0;

  wire         s_ready;
  wire         m_valid;
  wire  [31:0] m_data;
  wire         m_last;
  wire  [0:0]  m_user;
  wire  [31:0] prdata_w;
  wire         pready_w;

  four_neighbour_peak_clip_top u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last),
    .m_axis_tuser_o  (m_user),
    .psel            (psel_r),
    .penable         (penable_r),
    .pwrite          (pwrite_r),
    .paddr           (paddr_r),
    .pwdata          (pwdata_r),
    .prdata          (prdata_w),
    .pready          (pready_w)
  );

  always #6 clk = ~clk;

  pixel_t       pixels_to_send [$];
  clip_result_t clipped_q [$];
  int           fault_cnt = 0;
  int           src_wait  = 0;
  int           sink_wait = 0;
  int           idle_cycles = 0;
  bit           src_gappy  = 1'b1;
  bit           sink_gappy = 1'b1;

  // clip predictor state
  pixel_t       line_mem [ROWS][MAX_WIDTH];
  logic [5:0]   width_reg  = 6'd32;
  logic [15:0]  height_reg = 16'd1;
  int unsigned  col_pos = 0;
  int unsigned  row_pos = 0;

  function automatic int unsigned active_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int unsigned active_height();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  function automatic pixel_t clipped(int unsigned r, int unsigned c,
                                     int unsigned w, int unsigned h);
    pixel_t v;
    pixel_t m;
    v = line_mem[r % ROWS][c];
    m = '0;
    if (r > 0 && line_mem[(r - 1) % ROWS][c] > m) m = line_mem[(r - 1) % ROWS][c];
    if (r + 1 < h && line_mem[(r + 1) % ROWS][c] > m) m = line_mem[(r + 1) % ROWS][c];
    if (c > 0 && line_mem[r % ROWS][c - 1] > m) m = line_mem[r % ROWS][c - 1];
    if (c + 1 < w && line_mem[r % ROWS][c + 1] > m) m = line_mem[r % ROWS][c + 1];
    return (v > m) ? m : v;
  endfunction

  function automatic void note_result(pixel_t p, logic last, logic done);
    clip_result_t res;
    res.pix  = p;
    res.last = last;
    res.done = done;
    clipped_q.push_back(res);
  endfunction

  function automatic void accept_pixel(pixel_t px);
    int unsigned w;
    int unsigned h;
    int unsigned r;
    int unsigned c;
    bit          flush;
    w = active_width();
    h = active_height();
    r = row_pos;
    c = col_pos;
    if (c >= w) c = 0;
    if (r >= h) r = 0;
    line_mem[r % ROWS][c] = px;
    flush = (c + 1 == w) && (r + 1 == h);
    if (r >= 1) note_result(clipped(r - 1, c, w, h), !flush, 1'b0);
    if (flush) begin
      for (int unsigned k = 0; k < w; k++) begin
        note_result(clipped(r, k, w, h), k == w - 1, k == w - 1);
      end
      col_pos = 0;
      row_pos = 0;
    end else begin
      c++;
      if (c >= w) begin
        c = 0;
        r++;
      end
      col_pos = c;
      row_pos = r;
    end
  endfunction

  // stream driver
  always @(posedge clk) begin
    if (!s_valid || s_ready) begin
      if (s_valid) src_wait = src_gappy ? $urandom_range(0, 16) : 0;
      if (src_wait > 0) begin
        src_wait--;
        s_valid <= 1'b0;
      end else if (pixels_to_send.size() != 0) begin
        s_valid <= 1'b1;
        s_data  <= pixels_to_send.pop_front();
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // result checker, input observer and watchdog
  always @(posedge clk) begin : monitor
    clip_result_t want;
    if (rst_n) begin
      if (m_valid && m_ready) begin
        if (clipped_q.size() == 0) begin
          fault_cnt++;
          $display("%0t: unexpected result pixel %h last %b done %b",
                   $time, m_data, m_last, m_user[0]);
        end else begin
          want = clipped_q.pop_front();
          if (m_data !== want.pix || m_last !== want.last || m_user[0] !== want.done) begin
            fault_cnt++;
            $display("%0t: expected pixel %h last %b done %b, got pixel %h last %b done %b",
                     $time, want.pix, want.last, want.done, m_data, m_last, m_user[0]);
          end
        end
        sink_wait = sink_gappy ? $urandom_range(0, 16) : 0;
      end
      if (s_valid && s_ready) accept_pixel(s_data);
      if (sink_wait > 0) begin
        sink_wait--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
      if ((m_valid && m_ready) || (s_valid && s_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("four_neighbour_peak_clip_top: mismatch");
        $finish;
      end
    end
  end

  task automatic apb_write(reg_idx_e idx, logic [31:0] val);
    @(posedge clk);
    psel_r    <= 1'b1;
    penable_r <= 1'b0;
    pwrite_r  <= 1'b1;
    paddr_r   <= {idx, 2'b00};
    pwdata_r  <= val;
    @(posedge clk);
    penable_r <= 1'b1;
    @(posedge clk);
    psel_r    <= 1'b0;
    penable_r <= 1'b0;
    pwrite_r  <= 1'b0;
    if (idx == REG_FRAME_WIDTH) width_reg = val[5:0];
    else height_reg = val[15:0];
    col_pos = 0;
    row_pos = 0;
  endtask

  // wait until every pixel went in and every result came out; sampled at the
  // falling edge so driver and checker updates of the rising edge are settled
  task automatic drain();
    do @(negedge clk);
    while (pixels_to_send.size() != 0 || s_valid || clipped_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic pixel_t rand_pixel();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return $urandom_range(0, 3);
      2:       return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      default: return 32'hFFFF_FFF0 + $urandom_range(0, 15);
    endcase
  endfunction

  initial begin
    int unsigned w_sel;
    int unsigned h_sel;
    int unsigned we;
    int unsigned frame_len;
    int unsigned n;
    int unsigned sent;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // zero width and height: 1x1 frames
    apb_write(REG_FRAME_WIDTH, 32'd0);
    apb_write(REG_FRAME_HEIGHT, 32'd0);
    pixels_to_send.push_back(32'hFFFF_FFFF);
    pixels_to_send.push_back(32'h0000_0000);
    drain();

    // 2x3 with corner peaks and extreme values
    apb_write(REG_FRAME_WIDTH, 32'd2);
    apb_write(REG_FRAME_HEIGHT, 32'd3);
    pixels_to_send.push_back(32'd5);
    pixels_to_send.push_back(32'hFFFF_FFFF);
    pixels_to_send.push_back(32'd7);
    pixels_to_send.push_back(32'd3);
    pixels_to_send.push_back(32'd0);
    pixels_to_send.push_back(32'hFFFF_FFFE);
    drain();

    // single column
    apb_write(REG_FRAME_WIDTH, 32'd1);
    apb_write(REG_FRAME_HEIGHT, 32'd4);
    pixels_to_send.push_back(32'hFFFF_FFFF);
    pixels_to_send.push_back(32'd1);
    pixels_to_send.push_back(32'hFFFF_FFFF);
    pixels_to_send.push_back(32'd2);
    drain();

    // partial frame, then restart by a register write; ties are not clipped
    apb_write(REG_FRAME_WIDTH, 32'd3);
    apb_write(REG_FRAME_HEIGHT, 32'd2);
    pixels_to_send.push_back(32'd9);
    pixels_to_send.push_back(32'd9);
    pixels_to_send.push_back(32'd9);
    pixels_to_send.push_back(32'd1);
    drain();
    apb_write(REG_FRAME_WIDTH, 32'd3);
    pixels_to_send.push_back(32'd4);
    pixels_to_send.push_back(32'd4);
    pixels_to_send.push_back(32'd4);
    pixels_to_send.push_back(32'd4);
    pixels_to_send.push_back(32'd8);
    pixels_to_send.push_back(32'd4);
    drain();

    sent = 0;
    while (sent < 160) begin
      case ($urandom_range(0, 9))
        0:       w_sel = 0;
        1:       w_sel = 63;
        2:       w_sel = 32;
        3:       w_sel = $urandom_range(33, 62);
        default: w_sel = $urandom_range(1, 8);
      endcase
      we = (w_sel == 0) ? 1 : (w_sel > MAX_WIDTH ? MAX_WIDTH : w_sel);
      case ($urandom_range(0, 7))
        0:       h_sel = 0;
        1:       h_sel = 65535;
        default: h_sel = (we >= 16) ? $urandom_range(1, 2) : $urandom_range(1, 6);
      endcase
      if (h_sel == 65535) begin
        n = we * $urandom_range(1, 3) + $urandom_range(0, we - 1);
      end else begin
        frame_len = we * ((h_sel == 0) ? 1 : h_sel);
        if (frame_len > 1 && $urandom_range(0, 3) == 0) n = $urandom_range(1, frame_len - 1);
        else if (frame_len > 32) n = frame_len;
        else n = frame_len * $urandom_range(1, 2);
      end
      if (n > 160 - sent) n = 160 - sent;
      src_gappy  = $urandom_range(0, 2) != 0;
      sink_gappy = $urandom_range(0, 2) != 0;
      apb_write(REG_FRAME_WIDTH, w_sel);
      apb_write(REG_FRAME_HEIGHT, h_sel);
      for (int unsigned i = 0; i < n; i++) pixels_to_send.push_back(rand_pixel());
      sent += n;
      drain();
    end

    if (fault_cnt == 0) $display("four_neighbour_peak_clip_top: match");
    else $display("four_neighbour_peak_clip_top: mismatch");
    $finish;
  end

endmodule
